// File: hdl/rtp_pkg.sv
`timescale 1ns / 1ps

package rtp_pkg;

    // ascii codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_UPPER_O    = 8'h4F;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_UPPER_B    = 8'h42;

    localparam logic [6:0] DIGIT_NONE    = 7'd99;
    localparam logic [7:0] DEC_SPAN      = 8'd9;
    localparam logic [7:0] ALPHA_SPAN    = 8'd25;

    localparam logic [5:0] RADIX_RESET   = 6'd10;
    localparam logic [5:0] RADIX_AUTO    = 6'd0;
    localparam logic [5:0] RADIX_ONE     = 6'd1;
    localparam logic [5:0] RADIX_MAX     = 6'd36;
    localparam logic [5:0] RADIX_DEC     = 6'd10;
    localparam logic [5:0] RADIX_MIN     = 6'd2;
    localparam logic [5:0] RADIX_HEX     = 6'd16;
    localparam logic [5:0] RADIX_OCT     = 6'd8;
    localparam logic [5:0] RADIX_BIN     = 6'd2;

    localparam logic [70:0] LIMIT_POS    = 71'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [70:0] LIMIT_NEG    = 71'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_MAX      = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_BADBASE   = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_LEAD   = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_TRAIL  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       no_char;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [63:0] value;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic        is_negative;
        logic [63:0] magnitude;
        logic        seen_digit;
        logic        prev_underscore;
        status_t     error_code;
        logic [5:0]  active_base;
    } parse_state_t;

    // digit unit flags toward the step logic
    typedef struct packed {
        logic        is_blank;
        logic        is_underscore;
        logic        bad_digit;
        logic        overflow;
        logic [63:0] acc_value;
    } digit_res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] d_dec;
        logic [7:0] d_low;
        logic [7:0] d_up;
        d_dec = c - CH_ZERO;
        d_low = c - CH_LOWER_A;
        d_up  = c - CH_UPPER_A;
        if (d_dec <= DEC_SPAN)
            return d_dec[6:0];
        else if (d_low <= ALPHA_SPAN)
            return d_low[6:0] + 7'd10;
        else if (d_up <= ALPHA_SPAN)
            return d_up[6:0] + 7'd10;
        else
            return DIGIT_NONE;
    endfunction

    // 0 when the byte is no prefix letter
    function automatic logic [5:0] prefix_base(input logic [7:0] c);
        if ((c == CH_LOWER_X) || (c == CH_UPPER_X))
            return RADIX_HEX;
        else if ((c == CH_LOWER_O) || (c == CH_UPPER_O))
            return RADIX_OCT;
        else if ((c == CH_LOWER_B) || (c == CH_UPPER_B))
            return RADIX_BIN;
        else
            return RADIX_AUTO;
    endfunction

endpackage

// File: hdl/radix_integer_text_parser.sv
`timescale 1ns / 1ps

// radix integer text parser
// src channel: one text byte per beat (ch, no_char, is_last); a beat with
//   no_char set carries no byte, is_last closes the text
// res channel: one beat per text, status plus signed 64-bit value; value is
//   zero unless status is ok
// cfg port: cfg_we writes the 6-bit base register; the base is latched on
//   the first beat of each text, so writes take effect with the next text
// path: a last beat passes the input register, then the result register that drives res_valid
// throughput: one byte beat per cycle while src_stall is low, set by the combinational digit
//   multiply-accumulate (64x6 multiply, add, range compare) between the
//   input register and the parse state
// stall: the input register keeps taking beats while a result waits; only
//   a last beat meeting a full, stalled result register holds src_stall
// reset: parse state goes to start of text, base register to ten, both
//   beat registers empty
module radix_integer_text_parser
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                src_valid,
    output logic                src_stall,
    input  rtp_pkg::in_item_t   src_data,

    output logic                res_valid,
    input  logic                res_stall,
    output rtp_pkg::out_item_t  res_data,

    input  logic                cfg_we,
    input  logic [5:0]          cfg_wdata
);

    logic                  radix_reg;
    logic [5:0]            base_reg;
    logic                  in_valid_reg;
    rtp_pkg::in_item_t     in_item_reg;
    rtp_pkg::parse_state_t state_reg;
    rtp_pkg::parse_state_t state_next;
    logic                  res_valid_reg;
    rtp_pkg::out_item_t    res_item_reg;
    rtp_pkg::out_item_t    step_result;
    logic                  res_free;
    logic                  step_go;
    logic                  src_take;

    // output slot can take a new beat this cycle
    assign res_free  = !res_valid_reg || !res_stall;
    // non-last beats never touch the output slot
    assign step_go   = in_valid_reg && (!in_item_reg.is_last || res_free);
    assign src_stall = in_valid_reg && !step_go;
    assign src_take  = src_valid && !src_stall;

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

    // radix_reg flags that the base register was written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= 1'b0;
            base_reg  <= rtp_pkg::RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= 1'b1;
            base_reg  <= cfg_wdata;
        end
    end

    rtp_step u_step
    (
        .cur    (state_reg),
        .radix  (base_reg),
        .item   (in_item_reg),
        .nxt    (state_next),
        .result (step_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_take)
            in_valid_reg <= 1'b1;
        else if (step_go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
            in_item_reg <= src_data;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= rtp_pkg::PH_START;
            state_reg.is_negative     <= 1'b0;
            state_reg.magnitude       <= '0;
            state_reg.seen_digit      <= 1'b0;
            state_reg.prev_underscore <= 1'b0;
            state_reg.error_code      <= rtp_pkg::ST_OK;
            state_reg.active_base     <= rtp_pkg::RADIX_RESET;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step_go && in_item_reg.is_last)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_go && in_item_reg.is_last)
            res_item_reg <= step_result;
    end

`ifndef SYNTHESIS
    // an error result never carries a value
    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_item_reg.status != rtp_pkg::ST_OK)) |-> (res_item_reg.value == '0))
        else $error("error result with nonzero value");

    // the text state restarts after every last beat
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && in_item_reg.is_last) |=> (state_reg.phase == rtp_pkg::PH_START))
        else $error("parse state not restarted after last beat");

    // accumulated magnitude stays within the negative limit
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.magnitude <= rtp_pkg::MAG_MAX)
        else $error("magnitude beyond int64 range");

    // a pending underscore always follows a digit
    a_underscore_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.prev_underscore |-> state_reg.seen_digit)
        else $error("underscore flagged without a digit");

    // a base write is only seen at the base register after the edge
    a_cfg_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (radix_reg && (base_reg == $past(cfg_wdata))))
        else $error("base register missed a write");
`endif

endmodule

// File: hdl/rtp_digit.sv
`timescale 1ns / 1ps

module rtp_digit
(
    input  logic [7:0]          ch,
    input  logic [63:0]         magnitude,
    input  logic [5:0]          active_base,
    input  logic                is_negative,
    output rtp_pkg::digit_res_t res
);

    logic [5:0]  base_eff;
    logic [6:0]  dig;
    logic [69:0] prod;
    logic [70:0] acc;
    logic [70:0] limit;

    // base 0 means ten once past the prefix
    assign base_eff = (active_base == rtp_pkg::RADIX_AUTO) ? rtp_pkg::RADIX_DEC : active_base;
    assign dig      = rtp_pkg::digit_of(ch);
    assign prod     = 70'(magnitude) * 70'(base_eff);
    assign acc      = 71'(prod) + 71'(dig);
    assign limit    = is_negative ? rtp_pkg::LIMIT_NEG : rtp_pkg::LIMIT_POS;

    assign res.is_blank      = rtp_pkg::is_blank(ch);
    assign res.is_underscore = (ch == rtp_pkg::CH_UNDERSCORE);
    assign res.bad_digit     = (base_eff < rtp_pkg::RADIX_MIN) || (dig >= 7'(base_eff));
    // mag*base+d above the limit is the same test as the cutoff/cutlim pair
    assign res.overflow      = (acc > limit);
    assign res.acc_value     = acc[63:0];

endmodule

// File: hdl/rtp_step.sv
`timescale 1ns / 1ps

module rtp_step
(
    input  rtp_pkg::parse_state_t cur,
    input  logic [5:0]            radix,
    input  rtp_pkg::in_item_t     item,
    output rtp_pkg::parse_state_t nxt,
    output rtp_pkg::out_item_t    result
);

    rtp_pkg::parse_state_t s0;
    rtp_pkg::parse_state_t s;
    rtp_pkg::digit_res_t   dres;
    logic                  do_take;
    logic [5:0]            implied;
    logic [63:0]           neg_mag;

    // base latch at text start
    always_comb
    begin
        s0 = cur;
        if (cur.phase == rtp_pkg::PH_START)
        begin
            s0.active_base = radix;
            s0.error_code  = ((radix == rtp_pkg::RADIX_ONE) || (radix > rtp_pkg::RADIX_MAX))
                             ? rtp_pkg::ST_BADBASE : rtp_pkg::ST_OK;
            s0.phase       = rtp_pkg::PH_LEAD;
        end
    end

    rtp_digit u_digit
    (
        .ch          (item.ch),
        .magnitude   (s0.magnitude),
        .active_base (s0.active_base),
        .is_negative (s0.is_negative),
        .res         (dres)
    );

    assign implied = rtp_pkg::prefix_base(item.ch);
    assign neg_mag = ~s.magnitude + 64'd1;

    always_comb
    begin
        s       = s0;
        do_take = 1'b0;

        if (!item.no_char && (s0.error_code == rtp_pkg::ST_OK))
        begin
            case (s0.phase)
                rtp_pkg::PH_LEAD, rtp_pkg::PH_SIGNED:
                begin
                    if ((s0.phase == rtp_pkg::PH_LEAD) && dres.is_blank)
                    begin
                        s.phase = rtp_pkg::PH_LEAD;
                    end
                    else if ((s0.phase == rtp_pkg::PH_LEAD) &&
                             ((item.ch == rtp_pkg::CH_PLUS) || (item.ch == rtp_pkg::CH_MINUS)))
                    begin
                        s.is_negative = (item.ch == rtp_pkg::CH_MINUS);
                        s.phase       = rtp_pkg::PH_SIGNED;
                    end
                    else if (item.ch == rtp_pkg::CH_ZERO)
                    begin
                        s.phase = rtp_pkg::PH_ZERO;
                    end
                    else
                    begin
                        s.phase = rtp_pkg::PH_DIGITS;
                        do_take = 1'b1;
                    end
                end
                rtp_pkg::PH_ZERO:
                begin
                    s.phase = rtp_pkg::PH_DIGITS;
                    if ((implied != rtp_pkg::RADIX_AUTO) &&
                        ((s0.active_base == rtp_pkg::RADIX_AUTO) || (s0.active_base == implied)))
                    begin
                        s.active_base = implied;
                    end
                    else
                    begin
                        // the held zero counts as a digit of value zero
                        s.seen_digit = 1'b1;
                        do_take      = 1'b1;
                    end
                end
                rtp_pkg::PH_DIGITS:
                begin
                    do_take = 1'b1;
                end
                rtp_pkg::PH_TRAIL:
                begin
                    if (!dres.is_blank)
                        s.error_code = rtp_pkg::ST_MALFORMED;
                end
                default:
                begin
                    s.phase = s0.phase;
                end
            endcase
        end

        if (do_take)
        begin
            if (dres.is_blank)
            begin
                s.phase = rtp_pkg::PH_TRAIL;
            end
            else if (dres.is_underscore)
            begin
                if (!s.seen_digit || s.prev_underscore)
                    s.error_code = rtp_pkg::ST_MALFORMED;
                else
                    s.prev_underscore = 1'b1;
            end
            else if (dres.bad_digit)
            begin
                s.error_code = rtp_pkg::ST_MALFORMED;
            end
            else if (dres.overflow)
            begin
                s.error_code = rtp_pkg::ST_RANGE;
            end
            else
            begin
                s.magnitude       = dres.acc_value;
                s.seen_digit      = 1'b1;
                s.prev_underscore = 1'b0;
            end
        end

        if (item.is_last)
        begin
            // a lone zero at the end is the number zero
            if ((s.error_code == rtp_pkg::ST_OK) && (s.phase == rtp_pkg::PH_ZERO))
            begin
                s.phase      = rtp_pkg::PH_DIGITS;
                s.seen_digit = 1'b1;
            end
            if ((s.error_code == rtp_pkg::ST_OK) && (!s.seen_digit || s.prev_underscore))
                s.error_code = rtp_pkg::ST_MALFORMED;
        end
    end

    always_comb
    begin
        result.status = s.error_code;
        result.value  = '0;
        if (s.error_code == rtp_pkg::ST_OK)
            result.value = s.is_negative ? neg_mag : s.magnitude;

        nxt = s;
        if (item.is_last)
        begin
            nxt.phase           = rtp_pkg::PH_START;
            nxt.is_negative     = 1'b0;
            nxt.magnitude       = '0;
            nxt.seen_digit      = 1'b0;
            nxt.prev_underscore = 1'b0;
            nxt.error_code      = rtp_pkg::ST_OK;
            nxt.active_base     = radix;
        end
    end

endmodule

// File: dv/radix_integer_text_parser_tb.sv
`timescale 1ns / 1ps

module radix_integer_text_parser_tb;

    typedef logic [7:0] text_t[$];

    // clock, reset and block ports, all known from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    rtp_pkg::in_item_t  src_data = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    rtp_pkg::out_item_t res_data;
    logic               cfg_we = 1'b0;
    logic [5:0]         cfg_wdata = '0;

    // idle rates in percent, set per test
    int src_gap_pct = 0;
    int res_stall_pct = 0;

    // long receiver hold-off, requested by a test and counted by the receiver
    bit hold_request = 1'b0;
    int hold_left = 0;

    int byte_beats = 0;
    int fail_count = 0;

    // parse results still owed by the block, oldest first
    rtp_pkg::out_item_t parse_results_q[$];

    // shadow of the base register and of the text being parsed
    logic [5:0]       radix_shadow = rtp_pkg::RADIX_RESET;
    rtp_pkg::phase_t  txt_phase = rtp_pkg::PH_START;
    logic             txt_negative = 1'b0;
    logic [63:0]      txt_mag = '0;
    logic             txt_seen_digit = 1'b0;
    logic             txt_after_us = 1'b0;
    rtp_pkg::status_t txt_error = rtp_pkg::ST_OK;
    logic [5:0]       txt_base = rtp_pkg::RADIX_RESET;

    radix_integer_text_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // parse predictor
    // ------------------------------------------------------------------

    // space and the control range tab through carriage return
    function automatic bit blank_byte(input logic [7:0] c);
        return (c == rtp_pkg::CH_SPACE) || (c >= rtp_pkg::CH_TAB && c <= rtp_pkg::CH_CR);
    endfunction

    // digit weight of a byte, out of every base when it is no digit
    function automatic int unsigned digit_weight(input logic [7:0] c);
        if (c >= rtp_pkg::CH_ZERO && c <= rtp_pkg::CH_ZERO + 8'd9)
            return 32'(c - rtp_pkg::CH_ZERO);
        if (c >= rtp_pkg::CH_LOWER_A && c <= rtp_pkg::CH_LOWER_A + 8'd25)
            return 32'(c - rtp_pkg::CH_LOWER_A) + 10;
        if (c >= rtp_pkg::CH_UPPER_A && c <= rtp_pkg::CH_UPPER_A + 8'd25)
            return 32'(c - rtp_pkg::CH_UPPER_A) + 10;
        return 99;
    endfunction

    // base named by the letter after a leading zero, auto when none
    function automatic logic [5:0] letter_radix(input logic [7:0] c);
        case (c)
            rtp_pkg::CH_LOWER_X, rtp_pkg::CH_UPPER_X: return rtp_pkg::RADIX_HEX;
            rtp_pkg::CH_LOWER_O, rtp_pkg::CH_UPPER_O: return rtp_pkg::RADIX_OCT;
            rtp_pkg::CH_LOWER_B, rtp_pkg::CH_UPPER_B: return rtp_pkg::RADIX_BIN;
            default:                                  return rtp_pkg::RADIX_AUTO;
        endcase
    endfunction

    // the first error of a text wins
    task automatic flag_error(input rtp_pkg::status_t code);
        if (txt_error == rtp_pkg::ST_OK)
            txt_error = code;
    endtask

    // one byte while the digit run is open: digit, underscore or end blank
    task automatic accumulate_digit(input logic [7:0] c);
        int unsigned b;
        int unsigned d;
        logic [63:0] lim;
        logic [63:0] cut;
        logic [63:0] rem;
        b = (txt_base == rtp_pkg::RADIX_AUTO) ? int'(rtp_pkg::RADIX_DEC) : int'(txt_base);
        if (txt_error != rtp_pkg::ST_OK)
            return;
        if (blank_byte(c))
        begin
            txt_phase = rtp_pkg::PH_TRAIL;
            return;
        end
        if (c == rtp_pkg::CH_UNDERSCORE)
        begin
            if (!txt_seen_digit || txt_after_us)
                flag_error(rtp_pkg::ST_MALFORMED);
            else
                txt_after_us = 1'b1;
            return;
        end
        d = digit_weight(c);
        if (b < 2 || d >= b)
        begin
            flag_error(rtp_pkg::ST_MALFORMED);
            return;
        end
        // a negative text may reach one step further than a positive one
        lim = txt_negative ? rtp_pkg::MAG_MAX : rtp_pkg::MAG_MAX - 64'd1;
        cut = lim / 64'(b);
        rem = lim % 64'(b);
        if (txt_mag > cut || (txt_mag == cut && 64'(d) > rem))
        begin
            flag_error(rtp_pkg::ST_RANGE);
            return;
        end
        txt_mag = txt_mag * 64'(b) + 64'(d);
        txt_seen_digit = 1'b1;
        txt_after_us = 1'b0;
    endtask

    // one byte of content after the optional sign
    task automatic open_number(input logic [7:0] c);
        if (c == rtp_pkg::CH_ZERO)
            txt_phase = rtp_pkg::PH_ZERO;
        else
        begin
            txt_phase = rtp_pkg::PH_DIGITS;
            accumulate_digit(c);
        end
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic [5:0] named;
        if (txt_error != rtp_pkg::ST_OK)
            return;
        case (txt_phase)
            rtp_pkg::PH_LEAD:
            begin
                if (blank_byte(c))
                    return;
                if (c == rtp_pkg::CH_PLUS || c == rtp_pkg::CH_MINUS)
                begin
                    txt_negative = (c == rtp_pkg::CH_MINUS);
                    txt_phase = rtp_pkg::PH_SIGNED;
                end
                else
                    open_number(c);
            end
            rtp_pkg::PH_SIGNED:
                open_number(c);
            rtp_pkg::PH_ZERO:
            begin
                // a prefix letter counts only when the base allows it
                named = letter_radix(c);
                txt_phase = rtp_pkg::PH_DIGITS;
                if (named != rtp_pkg::RADIX_AUTO &&
                    (txt_base == rtp_pkg::RADIX_AUTO || txt_base == named))
                    txt_base = named;
                else
                begin
                    accumulate_digit(rtp_pkg::CH_ZERO);
                    accumulate_digit(c);
                end
            end
            rtp_pkg::PH_DIGITS:
                accumulate_digit(c);
            default:
                if (!blank_byte(c))
                    flag_error(rtp_pkg::ST_MALFORMED);
        endcase
    endtask

    // one accepted input beat; the last beat of a text owes one result
    task automatic advance_parse(input rtp_pkg::in_item_t beat);
        rtp_pkg::out_item_t r;
        if (txt_phase == rtp_pkg::PH_START)
        begin
            // base latch, also on a beat without a byte
            txt_base = radix_shadow;
            if (radix_shadow == rtp_pkg::RADIX_ONE || radix_shadow > rtp_pkg::RADIX_MAX)
                txt_error = rtp_pkg::ST_BADBASE;
            txt_phase = rtp_pkg::PH_LEAD;
        end
        if (!beat.no_char)
            scan_byte(beat.ch);
        if (!beat.is_last)
            return;
        // a lone zero is a complete number
        if (txt_error == rtp_pkg::ST_OK && txt_phase == rtp_pkg::PH_ZERO)
        begin
            txt_phase = rtp_pkg::PH_DIGITS;
            accumulate_digit(rtp_pkg::CH_ZERO);
        end
        if (txt_error == rtp_pkg::ST_OK && (!txt_seen_digit || txt_after_us))
            flag_error(rtp_pkg::ST_MALFORMED);
        r.status = txt_error;
        r.value = '0;
        if (txt_error == rtp_pkg::ST_OK)
            r.value = txt_negative ? 64'd0 - txt_mag : txt_mag;
        parse_results_q.push_back(r);
        txt_phase = rtp_pkg::PH_START;
        txt_negative = 1'b0;
        txt_mag = '0;
        txt_seen_digit = 1'b0;
        txt_after_us = 1'b0;
        txt_error = rtp_pkg::ST_OK;
        txt_base = radix_shadow;
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input rtp_pkg::out_item_t want,
                                   input rtp_pkg::out_item_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s: expected status %0d value %0d, got status %0d value %0d",
                     $time, what, want.status, want.value, got.status, got.value);
    endtask

    task automatic check_result(input rtp_pkg::out_item_t got);
        rtp_pkg::out_item_t want;
        if (parse_results_q.size() == 0)
        begin
            report_mismatch("result beat with nothing pending", '0, got);
            return;
        end
        want = parse_results_q.pop_front();
        if (got.status !== want.status)
            report_mismatch("status mismatch", want, got);
        if (got.value !== want.value)
            report_mismatch("value mismatch", want, got);
    endtask

    // sampled just after the edge, so every read sees the values the block saw
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                radix_shadow = cfg_wdata;
            if (src_valid && !src_stall)
                advance_parse(src_data);
            if (res_valid && !res_stall)
                check_result(res_data);
        end
    end

    // receiver: random stall, or a long hold-off when a test asks for one
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(0, 99) < res_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // valid stays high after the beat is taken; whoever stops sending lowers it
    task automatic send_beat(input logic [7:0] c, input logic empty, input logic last);
        rtp_pkg::in_item_t beat;
        beat.ch = c;
        beat.no_char = empty;
        beat.is_last = last;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data <= beat;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        if (!empty)
            byte_beats++;
    endtask

    // a text as byte beats; with sprinkle, empty beats fall in and may close it
    task automatic send_text(input text_t t, input bit sprinkle);
        bit tail_empty;
        tail_empty = (t.size() == 0) || (sprinkle && $urandom_range(0, 19) == 0);
        foreach (t[i])
        begin
            if (sprinkle && $urandom_range(0, 19) == 0)
                send_beat(8'($urandom), 1'b1, 1'b0);
            send_beat(t[i], 1'b0, !tail_empty && (i == t.size() - 1));
        end
        if (tail_empty)
            send_beat(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic send_str(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_text(t, 1'b0);
    endtask

    // sender pause: no beat offered until every owed result is back
    task automatic wait_results_done(input int settle);
        src_valid <= 1'b0;
        @(posedge clk);
        while (parse_results_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // the settle covers a text still in flight inside the block
    task automatic write_radix(input logic [5:0] r);
        wait_results_done(4);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 5) == 0)
            return rtp_pkg::CH_SPACE;
        return 8'($urandom_range(rtp_pkg::CH_TAB, rtp_pkg::CH_CR));
    endfunction

    function automatic logic [7:0] digit_glyph(input int unsigned d);
        if (d < 10)
            return rtp_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? rtp_pkg::CH_LOWER_A : rtp_pkg::CH_UPPER_A)
               + 8'(d - 10);
    endfunction

    function automatic logic [5:0] pick_radix();
        case ($urandom_range(0, 9))
            0, 1:    return rtp_pkg::RADIX_AUTO;
            2:       return rtp_pkg::RADIX_MIN;
            3:       return rtp_pkg::RADIX_MAX;
            4:       return rtp_pkg::RADIX_HEX;
            5:       return rtp_pkg::RADIX_OCT;
            6:       return rtp_pkg::RADIX_DEC;
            7:       return $urandom_range(0, 1)
                            ? rtp_pkg::RADIX_ONE
                            : 6'($urandom_range(rtp_pkg::RADIX_MAX + 1, 63));
            default: return 6'($urandom_range(rtp_pkg::RADIX_MIN, rtp_pkg::RADIX_MAX));
        endcase
    endfunction

    // well-formed number for the given base: blanks, sign, prefix, digits with underscores, blanks
    function automatic text_t number_text(input logic [5:0] r);
        text_t t;
        text_t digs;
        int unsigned b;
        logic [63:0] m;
        logic [5:0] pb;
        logic [7:0] letter;
        bit up;
        b = (r >= rtp_pkg::RADIX_MIN && r <= rtp_pkg::RADIX_MAX)
            ? int'(r) : int'(rtp_pkg::RADIX_DEC);
        repeat ($urandom_range(0, 2)) t.push_back(blank_char());
        case ($urandom_range(0, 3))
            0:       t.push_back(rtp_pkg::CH_PLUS);
            1:       t.push_back(rtp_pkg::CH_MINUS);
            default: ;
        endcase
        if ((r == rtp_pkg::RADIX_AUTO || r == rtp_pkg::RADIX_HEX ||
             r == rtp_pkg::RADIX_OCT || r == rtp_pkg::RADIX_BIN) && $urandom_range(0, 1))
        begin
            pb = r;
            if (r == rtp_pkg::RADIX_AUTO)
                case ($urandom_range(0, 2))
                    0:       pb = rtp_pkg::RADIX_HEX;
                    1:       pb = rtp_pkg::RADIX_OCT;
                    default: pb = rtp_pkg::RADIX_BIN;
                endcase
            up = 1'($urandom_range(0, 1));
            case (pb)
                rtp_pkg::RADIX_HEX: letter = up ? rtp_pkg::CH_UPPER_X : rtp_pkg::CH_LOWER_X;
                rtp_pkg::RADIX_OCT: letter = up ? rtp_pkg::CH_UPPER_O : rtp_pkg::CH_LOWER_O;
                default:            letter = up ? rtp_pkg::CH_UPPER_B : rtp_pkg::CH_LOWER_B;
            endcase
            b = 32'(pb);
            t.push_back(rtp_pkg::CH_ZERO);
            t.push_back(letter);
        end
        // mostly short numbers, some full width, some right at the int64 edge
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: m = 64'($urandom_range(0, 999));
            5, 6:          m = {$urandom, $urandom};
            7, 8:          m = 64'h7FFF_FFFF_FFFF_FFFD + 64'($urandom_range(0, 4));
            default:       m = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        do
        begin
            digs.push_front(digit_glyph(32'(m % 64'(b))));
            m = m / 64'(b);
        end
        while (m != 0);
        if ($urandom_range(0, 3) == 0)
            digs.push_front(rtp_pkg::CH_ZERO);
        foreach (digs[i])
        begin
            if (i != 0 && $urandom_range(0, 9) == 0)
                t.push_back(rtp_pkg::CH_UNDERSCORE);
            t.push_back(digs[i]);
        end
        repeat ($urandom_range(0, 2)) t.push_back(blank_char());
        return t;
    endfunction

    // mostly good numbers, some damaged ones, some raw byte noise
    function automatic text_t random_text(input logic [5:0] r);
        text_t t;
        int unsigned pick;
        int unsigned pos;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(0, 5)) t.push_back(8'($urandom));
            return t;
        end
        t = number_text(r);
        if (pick < 20)
        begin
            pos = $urandom_range(0, t.size());
            case ($urandom_range(0, 4))
                0: t[$urandom_range(0, t.size() - 1)] = 8'($urandom);
                1: t.insert(pos, rtp_pkg::CH_UNDERSCORE);
                2: t.insert(pos, blank_char());
                3: t.push_back(8'($urandom));
                // cut short: sign alone, prefix alone or nothing at all
                default: while (t.size() > pos) void'(t.pop_back());
            endcase
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // base ten from reset, no register write yet
    task automatic test_decimal_limits();
        send_str("  -9223372036854775808\t");
        send_str("+9223372036854775807");
        send_str("9223372036854775808");
        send_str("-9223372036854775809");
        send_str("0");
        send_str("-0\v");
    endtask

    task automatic test_malformed_text();
        send_str("");
        send_str(" \015\f");
        send_str("-");
        send_str("12 3");
        send_str("1_000");
        send_str("_1");
        send_str("1_");
        send_str("1__0");
        // range error found first stays over the later bad digit
        send_str("99999999999999999999x");
    endtask

    task automatic test_prefixes();
        write_radix(rtp_pkg::RADIX_AUTO);
        send_str("0x7FFFFFFFFFFFFFFF");
        send_str("-0X8000000000000000");
        send_str("0o17");
        send_str("0B101");
        send_str("0x");
        send_str("077");
        // prefix letter that does not match the base is a digit or an error
        write_radix(rtp_pkg::RADIX_HEX);
        send_str("0b1");
        send_str("0xfF");
        write_radix(rtp_pkg::RADIX_OCT);
        send_str("0x1");
    endtask

    task automatic test_base_extremes();
        write_radix(rtp_pkg::RADIX_MIN);
        send_str("102");
        send_str("-1");
        write_radix(rtp_pkg::RADIX_MAX);
        send_str("zZ_9");
        write_radix(rtp_pkg::RADIX_ONE);
        send_str("5");
        write_radix(rtp_pkg::RADIX_MAX + 6'd1);
        send_str("5");
        write_radix(6'h3F);
        send_str("");
    endtask

    // a write in the middle of a text only counts from the next text on
    task automatic test_base_latch();
        write_radix(rtp_pkg::RADIX_HEX);
        send_beat("1", 1'b0, 1'b0);
        send_beat("0", 1'b0, 1'b0);
        write_radix(rtp_pkg::RADIX_DEC);
        send_beat("f", 1'b0, 1'b1);
        send_str("f");
        write_radix(rtp_pkg::RADIX_HEX);
        send_beat(8'($urandom), 1'b1, 1'b0);
        write_radix(rtp_pkg::RADIX_DEC);
        send_str("a");
    endtask

    // receiver holds off while texts keep coming, until the block stalls input
    task automatic test_result_backlog();
        write_radix(rtp_pkg::RADIX_DEC);
        src_gap_pct = 0;
        res_stall_pct = 0;
        hold_request = 1'b1;
        repeat (12) send_text(number_text(rtp_pkg::RADIX_DEC), 1'b1);
        wait_results_done(4);
    endtask

    task automatic test_random_texts(input int n_bytes, input int src_pct,
                                     input int res_pct);
        int stop_at;
        int chunk_end;
        logic [5:0] r;
        src_gap_pct = src_pct;
        res_stall_pct = res_pct;
        stop_at = byte_beats + n_bytes;
        while (byte_beats < stop_at)
        begin
            r = pick_radix();
            write_radix(r);
            chunk_end = byte_beats + $urandom_range(20, 80);
            while (byte_beats < chunk_end)
                send_text(random_text(r), 1'b1);
        end
        wait_results_done(4);
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        src_gap_pct = 24;
        res_stall_pct = 88;
        test_decimal_limits();
        test_malformed_text();
        test_prefixes();
        test_base_extremes();
        test_base_latch();
        test_result_backlog();
        test_random_texts(300, 24, 88);
        test_random_texts(300, 88, 24);
        test_random_texts(300, 0, 0);
        wait_results_done(8);
        if (fail_count == 0 && parse_results_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
